[rtl/core/running_median_two_heaps_top_assert.svh]
// Assertion macros used by the running median datapath (rmth_dpath).
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RMTH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define RMTH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define RMTH_ASSERT(label, clk, rst, prop)
`define RMTH_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/rmth_pkg.sv]
package rmth_pkg;

   localparam int HEAP_DEPTH_DEFAULT = 512;
   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int COUNT_W  = 11;

   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_CAPTURE    = 4'd1,
      OP_DROP       = 4'd2,
      OP_INS_SAMPLE = 4'd3,
      OP_INS_MOVED  = 4'd4,
      OP_REP_SAMPLE = 4'd5,
      OP_INS_STEP   = 4'd6,
      OP_INS_CMP    = 4'd7,
      OP_REP_STEP   = 4'd8,
      OP_REP_LEFT   = 4'd9,
      OP_REP_RIGHT  = 4'd10,
      OP_REP_MOVE   = 4'd11,
      OP_FINISH     = 4'd12
   } op_type;

   typedef struct packed {
      op_type op;
      logic   side;   // 0 selects the lower (max) heap, 1 the upper (min) heap
   } cmd_type;

   typedef struct packed {
      logic counts_equal;
      logic lower_more;
      logic full;
      logic go_upper;
      logic idx_zero;
      logic ins_up;
      logic left_in;
      logic right_in;
      logic best_none;
   } status_type;

   // True when a must sit above b: min-heap order on the upper side, max-heap order on the lower.
   function automatic logic ranks_above(input logic signed [SAMPLE_W-1:0] a,
                                        input logic signed [SAMPLE_W-1:0] b,
                                        input logic is_min);
      ranks_above = is_min ? (a < b) : (a > b);
   endfunction

endpackage

[rtl/core/rmth_ctrl.sv]
module rmth_ctrl import rmth_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_DECIDE    = 10'b0000000010,
      ST_INS_STEP  = 10'b0000000100,
      ST_INS_CMP   = 10'b0000001000,
      ST_REP_STEP  = 10'b0000010000,
      ST_REP_LEFT  = 10'b0000100000,
      ST_REP_RIGHT = 10'b0001000000,
      ST_REP_MOVE  = 10'b0010000000,
      ST_INS2      = 10'b0100000000,
      ST_FINISH    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.side     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.full) begin
               cmd.op   = OP_DROP;
               state_in = ST_FINISH;
            end else if (status.counts_equal) begin
               cmd.op   = OP_INS_SAMPLE;
               cmd.side = status.go_upper;
               state_in = ST_INS_STEP;
            end else if (status.lower_more == status.go_upper) begin
               // The sample joins the smaller heap directly.
               cmd.op   = OP_INS_SAMPLE;
               cmd.side = status.go_upper;
               state_in = ST_INS_STEP;
            end else begin
               cmd.op   = OP_REP_SAMPLE;
               cmd.side = status.go_upper;
               state_in = ST_REP_STEP;
            end
         end
         ST_INS_STEP: begin
            cmd.op   = OP_INS_STEP;
            state_in = status.idx_zero ? ST_FINISH : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            cmd.op   = OP_INS_CMP;
            state_in = status.ins_up ? ST_INS_STEP : ST_FINISH;
         end
         ST_REP_STEP: begin
            cmd.op   = OP_REP_STEP;
            state_in = status.left_in ? ST_REP_LEFT : ST_INS2;
         end
         ST_REP_LEFT: begin
            cmd.op   = OP_REP_LEFT;
            state_in = status.right_in ? ST_REP_RIGHT : ST_REP_MOVE;
         end
         ST_REP_RIGHT: begin
            cmd.op   = OP_REP_RIGHT;
            state_in = ST_REP_MOVE;
         end
         ST_REP_MOVE: begin
            cmd.op   = OP_REP_MOVE;
            state_in = status.best_none ? ST_INS2 : ST_REP_STEP;
         end
         ST_INS2: begin
            cmd.op   = OP_INS_MOVED;
            state_in = ST_INS_STEP;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/rmth_dpath.sv]
`include "running_median_two_heaps_top_assert.svh"
module rmth_dpath import rmth_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic signed [MEDIAN_W-1:0] rsp_median_doubled,
   output logic                       rsp_dropped,
   output logic [COUNT_W-1:0]         rsp_sample_count
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int WW = AW + 2;

   logic signed [SAMPLE_W-1:0] mem_lo [HEAP_DEPTH];
   logic signed [SAMPLE_W-1:0] mem_hi [HEAP_DEPTH];
   logic signed [SAMPLE_W-1:0] q_lo_ff, q_hi_ff, rdata;

   logic [CW-1:0] lo_cnt_ff, hi_cnt_ff, cnt_sel;
   logic [AW-1:0] idx_ff, best_idx_ff, parent, raddr;
   logic [WW-1:0] left_w, right_w, cnt_w;
   logic          side_ff, best_none_ff, dropped_ff;
   logic signed [SAMPLE_W-1:0] sample_ff, val_ff, moved_ff, best_val_ff;
   logic signed [SAMPLE_W-1:0] top_lo_ff, top_hi_ff, wdata;
   logic signed [MEDIAN_W-1:0] median_ff, median_calc;
   logic signed [MEDIAN_W-1:0] med_out_ff;
   logic                       drop_out_ff;
   logic [COUNT_W-1:0]         count_out_ff;
   logic [CW:0]                cnt_sum;
   logic rd_en, wen, ins_up, left_pick, right_pick;

   assign rdata   = side_ff ? q_hi_ff : q_lo_ff;
   assign cnt_sel = side_ff ? hi_cnt_ff : lo_cnt_ff;
   assign parent  = AW'((idx_ff - AW'(1)) >> 1);
   assign left_w  = (WW'(idx_ff) << 1) + WW'(1);
   assign right_w = left_w + WW'(1);
   assign cnt_w   = WW'(cnt_sel);

   assign ins_up     = ranks_above(val_ff, rdata, side_ff);
   assign left_pick  = ranks_above(rdata, val_ff, side_ff);
   assign right_pick = ranks_above(rdata, best_val_ff, side_ff);

   always_comb begin
      status.counts_equal = (lo_cnt_ff == hi_cnt_ff);
      status.lower_more   = (lo_cnt_ff > hi_cnt_ff);
      status.full         = (lo_cnt_ff == hi_cnt_ff) && (lo_cnt_ff == CW'(HEAP_DEPTH));
      status.go_upper     = ($signed({sample_ff, 1'b0}) > median_ff);
      status.idx_zero     = (idx_ff == '0);
      status.ins_up       = ins_up;
      status.left_in      = (left_w < cnt_w);
      status.right_in     = (right_w < cnt_w);
      status.best_none    = best_none_ff;
   end

   // Memory port control for the heap selected by side_ff.
   always_comb begin
      rd_en = 1'b0;
      raddr = parent;
      wen   = 1'b0;
      wdata = val_ff;
      case (cmd.op)
         OP_INS_STEP: begin
            rd_en = !status.idx_zero;
            wen   = status.idx_zero;
         end
         OP_INS_CMP: begin
            wen   = 1'b1;
            wdata = ins_up ? rdata : val_ff;
         end
         OP_REP_STEP: begin
            raddr = left_w[AW-1:0];
            rd_en = status.left_in;
            wen   = !status.left_in;
         end
         OP_REP_LEFT: begin
            raddr = right_w[AW-1:0];
            rd_en = status.right_in;
         end
         OP_REP_MOVE: begin
            wen   = 1'b1;
            wdata = best_none_ff ? val_ff : best_val_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen && !side_ff) mem_lo[idx_ff] <= wdata;
      if (wen && side_ff)  mem_hi[idx_ff] <= wdata;
      if (rd_en && !side_ff) q_lo_ff <= mem_lo[raddr];
      if (rd_en && side_ff)  q_hi_ff <= mem_hi[raddr];
   end

   always_comb begin
      if (lo_cnt_ff == hi_cnt_ff) begin
         median_calc = MEDIAN_W'(top_lo_ff) + MEDIAN_W'(top_hi_ff);
      end else if (lo_cnt_ff > hi_cnt_ff) begin
         median_calc = {top_lo_ff, 1'b0};
      end else begin
         median_calc = {top_hi_ff, 1'b0};
      end
   end

   assign cnt_sum = {1'b0, lo_cnt_ff} + {1'b0, hi_cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_cnt_ff <= '0;
         hi_cnt_ff <= '0;
         median_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_INS_SAMPLE: begin
               if (cmd.side) hi_cnt_ff <= hi_cnt_ff + CW'(1);
               else          lo_cnt_ff <= lo_cnt_ff + CW'(1);
            end
            OP_INS_MOVED: begin
               if (!side_ff) hi_cnt_ff <= hi_cnt_ff + CW'(1);
               else          lo_cnt_ff <= lo_cnt_ff + CW'(1);
            end
            OP_FINISH: median_ff <= median_calc;
            default: begin
               median_ff <= median_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wen && idx_ff == '0) begin
         if (side_ff) top_hi_ff <= wdata;
         else         top_lo_ff <= wdata;
      end
      unique case (cmd.op)
         OP_CAPTURE: begin
            sample_ff  <= req_sample;
            dropped_ff <= 1'b0;
         end
         OP_DROP: dropped_ff <= 1'b1;
         OP_INS_SAMPLE: begin
            side_ff <= cmd.side;
            val_ff  <= sample_ff;
            idx_ff  <= cmd.side ? AW'(hi_cnt_ff) : AW'(lo_cnt_ff);
         end
         OP_INS_MOVED: begin
            side_ff <= !side_ff;
            val_ff  <= moved_ff;
            idx_ff  <= side_ff ? AW'(lo_cnt_ff) : AW'(hi_cnt_ff);
         end
         OP_REP_SAMPLE: begin
            side_ff  <= cmd.side;
            val_ff   <= sample_ff;
            idx_ff   <= '0;
            moved_ff <= cmd.side ? top_hi_ff : top_lo_ff;
         end
         OP_INS_CMP: begin
            if (ins_up) idx_ff <= parent;
         end
         OP_REP_LEFT: begin
            if (left_pick) begin
               best_val_ff  <= rdata;
               best_idx_ff  <= left_w[AW-1:0];
               best_none_ff <= 1'b0;
            end else begin
               best_val_ff  <= val_ff;
               best_none_ff <= 1'b1;
            end
         end
         OP_REP_RIGHT: begin
            if (right_pick) begin
               best_val_ff  <= rdata;
               best_idx_ff  <= right_w[AW-1:0];
               best_none_ff <= 1'b0;
            end
         end
         OP_REP_MOVE: begin
            if (!best_none_ff) idx_ff <= best_idx_ff;
         end
         OP_FINISH: begin
            med_out_ff   <= median_calc;
            drop_out_ff  <= dropped_ff;
            count_out_ff <= COUNT_W'(cnt_sum);
         end
         default: begin
            side_ff <= side_ff;
         end
      endcase
   end

   assign rsp_median_doubled = med_out_ff;
   assign rsp_dropped        = drop_out_ff;
   assign rsp_sample_count   = count_out_ff;

   `RMTH_ASSERT(a_balanced, clock, reset, (lo_cnt_ff == hi_cnt_ff) || ({1'b0, lo_cnt_ff} == {1'b0, hi_cnt_ff} + (CW+1)'(1)) || ({1'b0, hi_cnt_ff} == {1'b0, lo_cnt_ff} + (CW+1)'(1)))
   `RMTH_ASSERT(a_cnt_bound, clock, reset, (lo_cnt_ff <= CW'(HEAP_DEPTH)) && (hi_cnt_ff <= CW'(HEAP_DEPTH)))
   `RMTH_ASSERT_IMPL(a_write_in_heap, clock, reset, wen, WW'(idx_ff) < cnt_w)

endmodule

[rtl/core/running_median_two_heaps_top.sv]
// A dropped sample goes from the decide state straight to finish. Otherwise a sift-up
// level uses the step and compare states, and a sift-down level the step, left, optional
// right and move states, as each heap has a single memory port. Items go one at a time.
// A new item is taken while the previous result waits in the output register.
// Reset (synchronous, active high) clears counts, median and handshake state at once;
// heap memories are not cleared, since only entries below the counts are read.
module running_median_two_heaps_top import rmth_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [MEDIAN_W-1:0] rsp_median_doubled,
   output logic                       rsp_dropped,
   output logic [COUNT_W-1:0]         rsp_sample_count
);

   cmd_type    cmd;
   status_type status;

   rmth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rmth_dpath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_sample         (req_sample),
      .cmd                (cmd),
      .status             (status),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_dropped        (rsp_dropped),
      .rsp_sample_count   (rsp_sample_count)
   );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top import rmth_pkg::*; ();

   localparam int DEPTH = HEAP_DEPTH_DEFAULT;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic signed [MEDIAN_W-1:0] median_doubled;
      logic                       dropped;
      logic [COUNT_W-1:0]         sample_count;
   } median_result_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [MEDIAN_W-1:0] rsp_median_doubled;
   logic                       rsp_dropped;
   logic [COUNT_W-1:0]         rsp_sample_count;

   running_median_two_heaps_top dut (.*);

   // Predictor state: two heaps, their counts and twice the median.
   logic signed [SAMPLE_W-1:0] low_heap [DEPTH];
   logic signed [SAMPLE_W-1:0] high_heap [DEPTH];
   int unsigned low_cnt, high_cnt;
   longint median_x2;

   median_result_type pending_medians[$];
   int error_count;
   int send_idle_pct, recv_idle_pct;
   longint cycle_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bit outranks(input logic signed [SAMPLE_W-1:0] a,
                                   input logic signed [SAMPLE_W-1:0] b, input bit on_max);
      return on_max ? (a > b) : (a < b);
   endfunction

   task automatic heap_push(inout logic signed [SAMPLE_W-1:0] h [DEPTH],
                            inout int unsigned n, input logic signed [SAMPLE_W-1:0] v,
                            input bit on_max);
      int unsigned i, p;
      logic signed [SAMPLE_W-1:0] t;
      i = n;
      n = n + 1;
      h[i] = v;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!outranks(h[i], h[p], on_max)) break;
         t = h[i]; h[i] = h[p]; h[p] = t;
         i = p;
      end
   endtask

   task automatic heap_swap_top(inout logic signed [SAMPLE_W-1:0] h [DEPTH],
                                input int unsigned n, input logic signed [SAMPLE_W-1:0] v,
                                input bit on_max);
      int unsigned i, l, r, b;
      logic signed [SAMPLE_W-1:0] t;
      i = 0;
      h[0] = v;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         b = i;
         if (l < n && outranks(h[l], h[b], on_max)) b = l;
         if (r < n && outranks(h[r], h[b], on_max)) b = r;
         if (b == i) break;
         t = h[i]; h[i] = h[b]; h[b] = t;
         i = b;
      end
   endtask

   task automatic predict_median(input logic signed [SAMPLE_W-1:0] s);
      median_result_type r;
      logic signed [SAMPLE_W-1:0] moved;
      bit to_high;
      to_high = (2 * longint'(s)) > median_x2;
      r.dropped = 1'b0;
      if (low_cnt == high_cnt) begin
         if (low_cnt >= DEPTH) r.dropped = 1'b1;
         else if (to_high) begin
            heap_push(high_heap, high_cnt, s, 1'b0);
            median_x2 = 2 * longint'(high_heap[0]);
         end else begin
            heap_push(low_heap, low_cnt, s, 1'b1);
            median_x2 = 2 * longint'(low_heap[0]);
         end
      end else begin
         if (low_cnt > high_cnt) begin
            if (to_high) heap_push(high_heap, high_cnt, s, 1'b0);
            else begin
               moved = low_heap[0];
               heap_swap_top(low_heap, low_cnt, s, 1'b1);
               heap_push(high_heap, high_cnt, moved, 1'b0);
            end
         end else begin
            if (to_high) begin
               moved = high_heap[0];
               heap_swap_top(high_heap, high_cnt, s, 1'b0);
               heap_push(low_heap, low_cnt, moved, 1'b1);
            end else heap_push(low_heap, low_cnt, s, 1'b1);
         end
         median_x2 = longint'(low_heap[0]) + longint'(high_heap[0]);
      end
      r.median_doubled = median_x2[MEDIAN_W-1:0];
      r.sample_count = COUNT_W'(low_cnt + high_cnt);
      pending_medians.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Checker and receiver stall.
   always @(posedge clock) begin
      median_result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_medians.size() == 0) report_mismatch("result with none expected");
            else begin
               e = pending_medians.pop_front();
               if (rsp_median_doubled !== e.median_doubled)
                  report_mismatch($sformatf("median_doubled %0d, expected %0d",
                                            rsp_median_doubled, e.median_doubled));
               if (rsp_dropped !== e.dropped)
                  report_mismatch($sformatf("dropped %0b, expected %0b",
                                            rsp_dropped, e.dropped));
               if (rsp_sample_count !== e.sample_count)
                  report_mismatch($sformatf("sample_count %0d, expected %0d",
                                            rsp_sample_count, e.sample_count));
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Valid stays high after the accepting edge; the next call or the drain
   // task drives it again in that same time step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_median(s);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(5))
         0: return $urandom_range(40) - 20;
         1: return {1'b1, 31'($urandom_range(15))};
         2: return {1'b0, {27{1'b1}}, 4'($urandom_range(15))};
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes();
      logic signed [SAMPLE_W-1:0] picks [10];
      picks = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, -1, 1,
                32'sh7ffffffe, 32'sh80000001, 32'sh7fffffff};
      foreach (picks[i]) send_sample(picks[i]);
      for (int i = 0; i < 12; i++) send_sample($urandom_range(6) - 3);
      send_sample(32'hAAAAAAAA);
      send_sample(32'h55555555);
   endtask

   task automatic test_random_stream(input int n);
      for (int i = 0; i < n; i++) send_sample(pick_sample());
   endtask

   // Fill both heaps to the brim, then overflow so samples are dropped.
   task automatic test_full_heaps();
      while (low_cnt + high_cnt < 2 * DEPTH) send_sample(pick_sample());
      for (int i = 0; i < 6; i++) send_sample(pick_sample());
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      rsp_stall = 1'b0;
      cycle_count = 0;
      error_count = 0;
      low_cnt = 0;
      high_cnt = 0;
      median_x2 = 0;
      send_idle_pct = 33;
      recv_idle_pct = 81;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_random_stream(150);
      // Hold the sender back until every transfer has come out.
      drain_results();
      send_idle_pct = 81;
      recv_idle_pct = 33;
      test_random_stream(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_full_heaps();
      drain_results();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_medians.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

[running_median_two_heaps_top.f]
+incdir+rtl/core
rtl/core/rmth_pkg.sv
rtl/core/rmth_ctrl.sv
rtl/core/rmth_dpath.sv
rtl/core/running_median_two_heaps_top.sv
dv/tb_top.sv
